### hdl/cserl_pkg.sv
// shared constants, types and codes for the crc-stamped event ring log
package cserl_pkg;

    // ring depth and derived widths
    localparam int LOG_DEPTH = 16;
    localparam int PTR_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int POS_W     = 4;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int HELD_W    = 5;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_TOP   = 16'h8000;
    localparam int          CRC_BYTES = 9;
    localparam int          MSG_W     = 8 * CRC_BYTES;
    localparam int          BCNT_W    = $clog2(CRC_BYTES + 1);

    // record layout {type, uuid, param, length, crc}
    localparam int REC_W = 64;

    // request codes
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [1:0] {
        STAT_STORED  = 2'd0,
        STAT_READ_OK = 2'd1,
        STAT_BEYOND  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } crc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } crc_stat_t;

endpackage

### hdl/crc_stamped_event_ring_log_top.sv
// top level of the crc-stamped event ring log
//
// an overwrite-oldest ring of 16 event records, each stamped with a
// crc-16/ccitt-false over nine bytes (three zero spare bytes, type, uuid
// low/high, parameter id, length low/high). a store request writes a
// record at the write pointer and answers with the stored fields and
// their crc; a read request answers with the record at a position counted
// from the oldest held record, or with status "beyond" and zero fields
// when the position is not below the held count. one request is worked
// at a time: a store passes through the crc unit, which folds in one
// byte per cycle over nine bytes, then through its done flag, the memory
// write and the result load; a read passes through the memory's
// registered read port and then the result load, and a read beyond the
// count goes straight to the result load. the next request is taken in
// the cycle after the result is loaded, and the result side can stall a
// result that is ready to load. the result sits in an output register,
// so a new request is accepted while the previous result still waits to
// be taken. records live in a single-port-write, registered-read memory;
// entries are never read before they are written, so the memory needs no
// clearing after reset.
module crc_stamped_event_ring_log_top
    import cserl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  event_type,
    input  logic [15:0] svc_uuid,
    input  logic [7:0]  param_code,
    input  logic [15:0] data_length,
    input  logic [3:0]  read_position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_type,
    output logic [15:0] out_uuid,
    output logic [7:0]  out_param,
    output logic [15:0] out_length,
    output logic [15:0] out_crc,
    output logic [4:0]  entries_held
);

    // control state
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // request payload held while the request is worked
    logic [7:0]         type_reg;
    logic [15:0]        uuid_reg;
    logic [7:0]         param_reg;
    logic [15:0]        len_reg;
    status_t            kind_reg;
    logic [PTR_W-1:0]   rd_addr_reg;

    // result register
    status_t            status_reg;
    logic [7:0]         out_type_reg;
    logic [15:0]        out_uuid_reg;
    logic [7:0]         out_param_reg;
    logic [15:0]        out_len_reg;
    logic [15:0]        out_crc_reg;
    logic [HELD_W-1:0]  held_reg;

    // datapath
    logic               accept;
    logic               beyond;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [PTR_W-1:0]   start_idx;
    logic [PTR_W:0]     idx_sum;
    logic [PTR_W-1:0]   rd_idx;
    logic [MSG_W-1:0]   crc_msg;
    crc_ctrl_t          crc_ctrl;
    crc_stat_t          crc_stat;
    logic [15:0]        crc_value;
    logic               ram_we;
    logic               ram_re;
    logic [REC_W-1:0]   ram_wdata;
    logic [REC_W-1:0]   ram_rdata;
    logic               load_out;
    logic               log_full;

    assign accept   = in_valid && in_ready;
    assign log_full = (cnt_reg == CNT_W'(LOG_DEPTH));

    // read position check and ring index of the requested record
    assign pos_ext   = CMP_W'(read_position);
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign beyond    = (pos_ext >= cnt_ext);
    // when the ring is full the oldest record sits at the write pointer
    assign start_idx = log_full ? wp_reg : '0;
    assign idx_sum   = (PTR_W+1)'(start_idx) + (PTR_W+1)'(read_position);
    // sum stays below twice the depth, so one subtract wraps it
    assign rd_idx    = (idx_sum >= (PTR_W+1)'(LOG_DEPTH))
                     ? PTR_W'(idx_sum - (PTR_W+1)'(LOG_DEPTH))
                     : PTR_W'(idx_sum);

    // crc byte order: spare, spare, spare, type, uuid lo, uuid hi, param, len lo, len hi
    assign crc_msg = {24'h000000, event_type, svc_uuid[7:0], svc_uuid[15:8],
                      param_code, data_length[7:0], data_length[15:8]};

    assign ram_wdata = {type_reg, uuid_reg, param_reg, len_reg, crc_value};

    cserl_crc16 u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .msg   (crc_msg),
        .stat  (crc_stat),
        .crc   (crc_value)
    );

    cserl_ram u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .re      (ram_re),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_STORE)
                    begin
                        state_next = ST_CRC;
                    end
                    else if (beyond)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_CRC:
            begin
                if (crc_stat.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready       = 1'b0;
        crc_ctrl.start = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                crc_ctrl.start = in_valid && (req_type == REQ_STORE);
            end
            ST_CRC:
            begin
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    // pointer advances on the write, and the count too until the ring is full
    always_comb
    begin
        wp_next  = wp_reg;
        cnt_next = cnt_reg;
        if (ram_we)
        begin
            wp_next = (wp_reg == PTR_W'(LOG_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (!log_full)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg    <= event_type;
            uuid_reg    <= svc_uuid;
            param_reg   <= param_code;
            len_reg     <= data_length;
            rd_addr_reg <= rd_idx;
            if (req_type == REQ_STORE)
            begin
                kind_reg <= STAT_STORED;
            end
            else if (beyond)
            begin
                kind_reg <= STAT_BEYOND;
            end
            else
            begin
                kind_reg <= STAT_READ_OK;
            end
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= kind_reg;
            held_reg   <= HELD_W'(cnt_reg);
            case (kind_reg)
                STAT_STORED:
                begin
                    out_type_reg  <= type_reg;
                    out_uuid_reg  <= uuid_reg;
                    out_param_reg <= param_reg;
                    out_len_reg   <= len_reg;
                    out_crc_reg   <= crc_value;
                end
                STAT_READ_OK:
                begin
                    out_type_reg  <= ram_rdata[63:56];
                    out_uuid_reg  <= ram_rdata[55:40];
                    out_param_reg <= ram_rdata[39:32];
                    out_len_reg   <= ram_rdata[31:16];
                    out_crc_reg   <= ram_rdata[15:0];
                end
                default:
                begin
                    out_type_reg  <= '0;
                    out_uuid_reg  <= '0;
                    out_param_reg <= '0;
                    out_len_reg   <= '0;
                    out_crc_reg   <= '0;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_type     = out_type_reg;
    assign out_uuid     = out_uuid_reg;
    assign out_param    = out_param_reg;
    assign out_length   = out_len_reg;
    assign out_crc      = out_crc_reg;
    assign entries_held = held_reg;

endmodule

### hdl/cserl_ram.sv
// record memory: one write port, one registered read port
module cserl_ram
    import cserl_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [PTR_W-1:0] wr_addr,
    input  logic [REC_W-1:0] wr_data,
    input  logic             re,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [REC_W-1:0] rd_data
);

    logic [REC_W-1:0] mem [LOG_DEPTH];
    logic [REC_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/cserl_crc16.sv
// byte-serial crc-16/ccitt-false unit, one message byte per cycle
module cserl_crc16
    import cserl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  crc_ctrl_t        ctrl,
    input  logic [MSG_W-1:0] msg,
    output crc_stat_t        stat,
    output logic [15:0]      crc
);

    logic [15:0]       crc_reg;
    logic [15:0]       crc_next;
    logic [MSG_W-1:0]  msg_reg;
    logic [BCNT_W-1:0] bcnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              last_byte;

    // one byte through the polynomial, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    assign crc_next  = crc_byte(crc_reg, msg_reg[MSG_W-1 -: 8]);
    assign last_byte = (bcnt_reg == BCNT_W'(CRC_BYTES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bcnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                bcnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                bcnt_reg <= bcnt_reg + 1'b1;
                if (last_byte)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            crc_reg <= CRC_INIT;
            msg_reg <= msg;
        end
        else if (busy_reg)
        begin
            crc_reg <= crc_next;
            msg_reg <= msg_reg << 8;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign crc       = crc_reg;

endmodule

### hdl/cserl_checker.sv
// port-level checks for the ring log top, bound to the top level
module cserl_checker
    import cserl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  out_type,
    input logic [15:0] out_uuid,
    input logic [7:0]  out_param,
    input logic [15:0] out_length,
    input logic [15:0] out_crc,
    input logic [4:0]  entries_held
);

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // one request in flight: no acceptance right after another
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is worked");

    // beyond-count results carry zero fields
    a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_BEYOND) |->
            (out_type == 8'h00) && (out_uuid == 16'h0000) && (out_param == 8'h00)
            && (out_length == 16'h0000) && (out_crc == 16'h0000))
        else $error("beyond-count result with nonzero fields");

    // a store or a good read implies at least one held record
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == STAT_STORED) || (status == STAT_READ_OK)) |->
            (entries_held != 5'd0))
        else $error("record result with empty log");

    // held count never passes the depth and status is a known code
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entries_held <= HELD_W'(LOG_DEPTH)) && (status != 2'd3))
        else $error("held count or status out of range");

endmodule

bind crc_stamped_event_ring_log_top cserl_checker u_cserl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_type     (out_type),
    .out_uuid     (out_uuid),
    .out_param    (out_param),
    .out_length   (out_length),
    .out_crc      (out_crc),
    .entries_held (entries_held)
);
